@@ hw/rtl/jsu_pkg.sv @@
// jsu_pkg: shared types and status codes of the json string decoder.
// used by jsu_front, jsu_queue, jsu_back and json_string_unescape_utf8.
`default_nettype none

package jsu_pkg;

  localparam logic [3:0] StData      = 4'd0;
  localparam logic [3:0] StClosed    = 4'd1;
  localparam logic [3:0] StCtrlByte  = 4'd2;
  localparam logic [3:0] StBadEsc    = 4'd3;
  localparam logic [3:0] StBadHex    = 4'd4;
  localparam logic [3:0] StLoneLow   = 4'd5;
  localparam logic [3:0] StBadLow    = 4'd6;
  localparam logic [3:0] StTruncated = 4'd7;
  localparam logic [3:0] StNoQuote   = 4'd8;

  // one job from front to back: a status, a raw byte or a code point
  typedef struct packed {
    logic [3:0]  status;
    logic        raw;
    logic [20:0] cp;
  } job_t;

endpackage

`default_nettype wire

@@ hw/rtl/jsu_front.sv @@
// jsu_front: accepts source bytes, tracks string/escape/hex phase and emits jobs.
// depends on jsu_pkg.
`default_nettype none

module jsu_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic          op_i,
  input  wire logic [7:0]    in_byte_i,
  output jsu_pkg::job_t      job_o,
  output logic               job_valid_o
);

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhStr    = 3'd1;
  localparam logic [2:0] PhEsc    = 3'd2;
  localparam logic [2:0] PhHex1   = 3'd3;
  localparam logic [2:0] PhWantBs = 3'd4;
  localparam logic [2:0] PhWantU  = 3'd5;
  localparam logic [2:0] PhHex2   = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [11:0] accum_q, accum_d;
  logic [1:0]  digits_q, digits_d;
  logic [9:0]  high_q, high_d;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] full_val;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      hex_val = 4'(in_byte_i - 8'h57);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      hex_val = 4'(in_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign full_val = {accum_q, hex_val};

  always_comb begin
    phase_d     = phase_q;
    accum_d     = accum_q;
    digits_d    = digits_q;
    high_d      = high_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    if (accept_i) begin
      if (phase_q == PhIdle || phase_q > PhHex2) begin
        phase_d = PhIdle;
        if (op_i) begin
          job_valid_o  = 1'b1;
          job_o.status = jsu_pkg::StNoQuote;
        end else if (in_byte_i == 8'h20 || in_byte_i == 8'h09 ||
                     in_byte_i == 8'h0d || in_byte_i == 8'h0a) begin
          phase_d = PhIdle;
        end else if (in_byte_i == 8'h22) begin
          phase_d = PhStr;
        end else begin
          job_valid_o  = 1'b1;
          job_o.status = jsu_pkg::StNoQuote;
        end
      end else if (op_i) begin
        phase_d      = PhIdle;
        job_valid_o  = 1'b1;
        job_o.status = jsu_pkg::StTruncated;
      end else begin
        unique case (phase_q)
          PhStr: begin
            if (in_byte_i == 8'h22) begin
              phase_d      = PhIdle;
              job_valid_o  = 1'b1;
              job_o.status = jsu_pkg::StClosed;
            end else if (in_byte_i < 8'h20) begin
              phase_d      = PhIdle;
              job_valid_o  = 1'b1;
              job_o.status = jsu_pkg::StCtrlByte;
            end else if (in_byte_i == 8'h5c) begin
              phase_d = PhEsc;
            end else begin
              job_valid_o = 1'b1;
              job_o.raw   = 1'b1;
              job_o.cp    = 21'(in_byte_i);
            end
          end
          PhEsc: begin
            phase_d     = PhStr;
            job_valid_o = 1'b1;
            job_o.raw   = 1'b1;
            unique case (in_byte_i)
              8'h22:   job_o.cp = 21'h22;
              8'h5c:   job_o.cp = 21'h5c;
              8'h2f:   job_o.cp = 21'h2f;
              8'h62:   job_o.cp = 21'h08;
              8'h66:   job_o.cp = 21'h0c;
              8'h6e:   job_o.cp = 21'h0a;
              8'h72:   job_o.cp = 21'h0d;
              8'h74:   job_o.cp = 21'h09;
              8'h75: begin
                job_valid_o = 1'b0;
                phase_d     = PhHex1;
                digits_d    = 2'd0;
              end
              default: begin
                phase_d      = PhIdle;
                job_o.raw    = 1'b0;
                job_o.status = jsu_pkg::StBadEsc;
              end
            endcase
          end
          PhWantBs: begin
            if (in_byte_i != 8'h5c) begin
              phase_d      = PhIdle;
              job_valid_o  = 1'b1;
              job_o.status = jsu_pkg::StBadLow;
            end else begin
              phase_d = PhWantU;
            end
          end
          PhWantU: begin
            if (in_byte_i != 8'h75) begin
              phase_d      = PhIdle;
              job_valid_o  = 1'b1;
              job_o.status = jsu_pkg::StBadLow;
            end else begin
              phase_d  = PhHex2;
              digits_d = 2'd0;
            end
          end
          default: begin
            // hex digit groups
            if (!hex_ok) begin
              phase_d      = PhIdle;
              job_valid_o  = 1'b1;
              job_o.status = jsu_pkg::StBadHex;
            end else if (digits_q != 2'd3) begin
              accum_d  = {accum_q[7:0], hex_val};
              digits_d = digits_q + 2'd1;
            end else begin
              digits_d = 2'd0;
              if (phase_q == PhHex1) begin
                if (full_val[15:10] == 6'b110110) begin
                  high_d  = full_val[9:0];
                  phase_d = PhWantBs;
                end else if (full_val[15:10] == 6'b110111) begin
                  phase_d      = PhIdle;
                  job_valid_o  = 1'b1;
                  job_o.status = jsu_pkg::StLoneLow;
                end else begin
                  phase_d     = PhStr;
                  job_valid_o = 1'b1;
                  job_o.cp    = 21'(full_val);
                end
              end else begin
                if (full_val[15:10] != 6'b110111) begin
                  phase_d      = PhIdle;
                  job_valid_o  = 1'b1;
                  job_o.status = jsu_pkg::StBadLow;
                end else begin
                  phase_d     = PhStr;
                  job_valid_o = 1'b1;
                  job_o.cp    = {11'(high_q) + 11'd64, full_val[9:0]};
                end
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      accum_q  <= '0;
      digits_q <= '0;
      high_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      accum_q  <= accum_d;
      digits_q <= digits_d;
      high_q   <= high_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/jsu_queue.sv @@
// jsu_queue: short job queue between front and back.
// depends on jsu_pkg.
`default_nettype none

module jsu_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire jsu_pkg::job_t wr_data_i,
  input  wire logic          rd_i,
  output jsu_pkg::job_t      rd_data_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jsu_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/jsu_back.sv @@
// jsu_back: expands queued jobs into utf-8 result bytes or a status result.
// depends on jsu_pkg; holds the output register.
`default_nettype none

module jsu_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire jsu_pkg::job_t job_i,
  input  wire logic          job_valid_i,
  output logic               job_pop_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output logic [7:0]         out_byte_o,
  output logic               byte_valid_o,
  output logic [3:0]         status_o,
  output logic               last_o
);

  logic [1:0] idx_q, idx_d;
  logic [1:0] last_idx, sel;
  logic       load, is_status, is_last;
  logic [7:0] byte_d;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       byte_valid_q;
  logic [3:0] status_q;
  logic       last_q;

  assign is_status = (job_i.status != jsu_pkg::StData);

  always_comb begin
    if (is_status || job_i.raw || job_i.cp[20:7] == '0) begin
      last_idx = 2'd0;
    end else if (job_i.cp[20:11] == '0) begin
      last_idx = 2'd1;
    end else if (job_i.cp[20:16] == '0) begin
      last_idx = 2'd2;
    end else begin
      last_idx = 2'd3;
    end
  end

  assign sel = last_idx - idx_q;

  always_comb begin
    if (idx_q == 2'd0) begin
      unique case (last_idx)
        2'd0:    byte_d = is_status ? 8'h00 : job_i.cp[7:0];
        2'd1:    byte_d = {3'b110, job_i.cp[10:6]};
        2'd2:    byte_d = {4'b1110, job_i.cp[15:12]};
        default: byte_d = {5'b11110, job_i.cp[20:18]};
      endcase
    end else begin
      unique case (sel)
        2'd0:    byte_d = {2'b10, job_i.cp[5:0]};
        2'd1:    byte_d = {2'b10, job_i.cp[11:6]};
        default: byte_d = {2'b10, job_i.cp[17:12]};
      endcase
    end
  end

  assign load      = job_valid_i && (!out_valid_q || pop_i);
  assign is_last   = (idx_q == last_idx);
  assign job_pop_o = load && is_last;
  assign idx_d     = load ? (is_last ? 2'd0 : idx_q + 2'd1) : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q   <= byte_d;
      byte_valid_q <= !is_status;
      status_q     <= job_i.status;
      last_q       <= is_last;
    end
  end

  assign empty_o      = !out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

@@ hw/rtl/json_string_unescape_utf8.sv @@
// json_string_unescape_utf8: json string literal decoder producing utf-8 bytes.
// depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
//   channel | handshake          | fields
//   --------+--------------------+---------------------------------------------
//   input   | push / full        | op_i, in_byte_i
//   result  | pop / empty        | out_byte_o, byte_valid_o, status_o, last_o
//
// one source byte is taken every cycle while full is low; its first result passes
// through the job queue and the output register before reaching the result ports.
// a \u escape gives up to four result bytes, one per cycle from the back end while
// results are popped; the job queue (QueueDepth entries) absorbs these bursts.
// full follows the job queue; result stalls back up through the queue only.
// reset clears the parse phase, the queue and the output register's valid flag.
`default_nettype none

module json_string_unescape_utf8 #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       op_i,
  input  wire logic [7:0] in_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic [3:0]      status_o,
  output logic            last_o
);

  jsu_pkg::job_t front_job, head_job;
  logic          front_job_valid, accept;
  logic          q_full, q_empty, q_pop;

  assign accept = push && !q_full;
  assign full   = q_full;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_i),
    .in_byte_i   (in_byte_i),
    .job_o       (front_job),
    .job_valid_o (front_job_valid)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_job_valid),
    .wr_data_i (front_job),
    .rd_i      (q_pop),
    .rd_data_o (head_job),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (head_job),
    .job_valid_i  (!q_empty),
    .job_pop_o    (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != jsu_pkg::StData) |-> (last_o && !byte_valid_o))
    else $error("status result without last or with byte");

  a_data_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == jsu_pkg::StData) |-> byte_valid_o)
    else $error("data result without byte");

  a_job_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_job_valid |=> !q_empty)
    else $error("job lost between front and queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

endmodule

`default_nettype wire
